[sv/keychain_xor_packet_decryptor_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the keychain XOR packet decryptor
// Shared checks, clocked on clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef KEYCHAIN_XOR_PACKET_DECRYPTOR_MACROS_SVH
`define KEYCHAIN_XOR_PACKET_DECRYPTOR_MACROS_SVH

// Property that must hold at every clock edge out of reset.
`define KXD_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Consequent that must hold in the cycle after the antecedent.
`define KXD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[sv/kxd_pkg.sv]
// ----------------------------------------------------------------------------
// kxd_pkg
// Types, constants and helpers shared by the keychain XOR decryptor modules.
// ----------------------------------------------------------------------------
package kxd_pkg;

	// Data widths.
	localparam int WORD_W      = 32;
	localparam int HALF_W      = 16;
	localparam int COUNT_W     = 3;
	localparam int CFG_IDX_W   = 2;

	// Chain index taken from the raw word, and the span it covers.
	localparam int IDX_W       = 14;
	localparam int IDX_SPAN    = 16384;

	// Default key table depth.
	localparam int DEF_KEY_ENTRIES = 16384;

	// Register indexes on the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_TABLE_SEED = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_START_KEY  = 2'd1;

	// Register reset values.
	localparam logic [WORD_W-1:0] TABLE_SEED_RST = 32'h8F54C37B;
	localparam logic [WORD_W-1:0] START_KEY_RST  = 32'h7AB38CF1;

	// Linear congruential generator constants.
	localparam logic [WORD_W-1:0] GEN_MUL  = 32'h02F6B6F5;
	localparam logic [WORD_W-1:0] GEN_ADD  = 32'h014698B7;
	localparam logic [WORD_W-1:0] OUT_MUL  = 32'h027F41C3;
	localparam logic [WORD_W-1:0] OUT_ADD  = 32'h00B327BD;

	// A full word carries this many bytes.
	localparam logic [COUNT_W-1:0] FULL_COUNT = 3'd4;

	// Write request from the table fill sequencer.
	typedef struct packed {
		logic              we;
		logic [WORD_W-1:0] data;
	} fill_wr_t;

	// Bytes of the key that are applied for a given byte count.
	function automatic logic [WORD_W-1:0] xor_mask(input logic [COUNT_W-1:0] count);
		logic [WORD_W-1:0] m;
		case (count)
			3'd0:    m = 32'h00000000;
			3'd1:    m = 32'h000000FF;
			3'd2:    m = 32'h0000FFFF;
			3'd3:    m = 32'h00FFFFFF;
			default: m = 32'hFFFFFFFF;
		endcase
		return m;
	endfunction

endpackage

[sv/kxd_ram.sv]
// ----------------------------------------------------------------------------
// kxd_ram
// Simple dual-port synchronous RAM: one write port, one read port with a
// registered read.
// ----------------------------------------------------------------------------
module kxd_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16384
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read port; data holds until the next read.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[sv/kxd_fill.sv]
// ----------------------------------------------------------------------------
// kxd_fill
// Key table fill sequencer. Steps the generator once per cycle and writes
// one table entry from each pair of generator outputs, low half first.
// ----------------------------------------------------------------------------
module kxd_fill #(
	parameter int KEY_ENTRIES = kxd_pkg::DEF_KEY_ENTRIES
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [kxd_pkg::WORD_W-1:0]     seed,
	output logic                           busy,
	output logic [$clog2(KEY_ENTRIES)-1:0] addr,
	output kxd_pkg::fill_wr_t              wr
);

	localparam int AW = $clog2(KEY_ENTRIES);
	localparam logic [AW-1:0] LAST_IDX = AW'(KEY_ENTRIES - 1);

	typedef enum logic [1:0] {
		F_IDLE,
		F_START,
		F_FILL
	} fill_state_t;

	fill_state_t                state_q;
	logic [AW-1:0]              idx_q;
	logic                       phase_q;
	logic                       have_q;
	logic [kxd_pkg::HALF_W-1:0] lo_q;
	logic [kxd_pkg::WORD_W-1:0] gen_q;
	logic [kxd_pkg::WORD_W-1:0] gen_next;
	logic [kxd_pkg::WORD_W-1:0] out_prod;
	logic [kxd_pkg::HALF_W-1:0] gen_out;
	logic                       wr_en;

	// Generator recurrence and output scramble of the current state.
	always_comb begin
		gen_next = kxd_pkg::WORD_W'(gen_q * kxd_pkg::GEN_MUL) + kxd_pkg::GEN_ADD;
		out_prod = kxd_pkg::WORD_W'({16'd0, gen_q[31:16]} * kxd_pkg::OUT_MUL)
			+ kxd_pkg::OUT_ADD;
		gen_out  = out_prod[31:16];
	end

	// An entry is written when the high half is produced.
	assign wr_en   = (state_q == F_FILL) && have_q && phase_q;
	assign wr.we   = wr_en;
	assign wr.data = {gen_out, lo_q};
	assign addr    = idx_q;
	assign busy    = (state_q != F_IDLE);

	// Fill state machine; a fill starts out of reset and on request.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_START;
			idx_q   <= '0;
			phase_q <= 1'b0;
			have_q  <= 1'b0;
		end else begin
			case (state_q)
				F_IDLE: begin
					if (start) begin
						state_q <= F_START;
					end
				end
				F_START: begin
					idx_q   <= '0;
					phase_q <= 1'b0;
					have_q  <= 1'b0;
					// A request arriving here keeps the state in F_START so that
					// the generator loads the newly written seed.
					if (!start) begin
						state_q <= F_FILL;
					end
				end
				F_FILL: begin
					have_q <= 1'b1;
					if (start) begin
						state_q <= F_START;
					end else if (have_q) begin
						phase_q <= ~phase_q;
						if (phase_q) begin
							if (idx_q == LAST_IDX) begin
								state_q <= F_IDLE;
							end else begin
								idx_q <= idx_q + AW'(1);
							end
						end
					end
				end
				default: begin
					state_q <= F_IDLE;
				end
			endcase
		end
	end

	// Generator state and the held low half.
	always_ff @(posedge clk) begin
		if (state_q == F_START) begin
			gen_q <= seed;
		end else begin
			gen_q <= gen_next;
		end
		if (have_q && !phase_q) begin
			lo_q <= gen_out;
		end
	end

endmodule

[sv/keychain_xor_packet_decryptor.sv]
// ----------------------------------------------------------------------------
// keychain_xor_packet_decryptor
// An accepted word is registered and reaches the output in the next cycle.
// Throughput: one word per cycle unless a fill runs or the output stalls; the
// chain key comes from one table read per full word, registered in the key RAM
// and forwarded to the following word. Reset and every write to a valid
// register run a table fill, one generator step per cycle, with s_tready low.
// ----------------------------------------------------------------------------
module keychain_xor_packet_decryptor #(
	parameter int KEY_ENTRIES = kxd_pkg::DEF_KEY_ENTRIES
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// Input stream.
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [39:0]                       s_tdata,  // raw_word, byte_count, zero pad
	input  logic                              s_tuser,  // packet_start
	// Output stream.
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [31:0]                       m_tdata,  // plain_word
	output logic                              m_tlast,  // is_tail
	// Configuration writes.
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [kxd_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [kxd_pkg::WORD_W-1:0]        cfg_data
);

	`include "keychain_xor_packet_decryptor_macros.svh"

	localparam int AW     = $clog2(KEY_ENTRIES);
	localparam int QSTEPS = $clog2((kxd_pkg::IDX_SPAN + KEY_ENTRIES - 1) / KEY_ENTRIES);

	logic [kxd_pkg::WORD_W-1:0]  table_seed_q;
	logic [kxd_pkg::WORD_W-1:0]  start_key_q;
	logic [kxd_pkg::WORD_W-1:0]  chain_q;
	logic                        pend_q;
	logic                        m_tvalid_q;
	logic [kxd_pkg::WORD_W-1:0]  m_tdata_q;
	logic                        m_tlast_q;

	logic                        cfg_we;
	logic                        fill_busy;
	logic [AW-1:0]               fill_addr;
	kxd_pkg::fill_wr_t           fill_wr;

	logic                        s_acc;
	logic [kxd_pkg::WORD_W-1:0]  raw;
	logic [kxd_pkg::COUNT_W-1:0] count;
	logic                        is_full;
	logic [kxd_pkg::WORD_W-1:0]  key;
	logic [kxd_pkg::WORD_W-1:0]  rd_data;
	logic [kxd_pkg::IDX_W:0]     rem;
	logic [AW-1:0]               rd_idx;

	// Configuration registers; a write to a known register restarts the fill.
	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid && cfg_ready
		&& ((cfg_index == kxd_pkg::REG_TABLE_SEED) || (cfg_index == kxd_pkg::REG_START_KEY));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			table_seed_q <= kxd_pkg::TABLE_SEED_RST;
			start_key_q  <= kxd_pkg::START_KEY_RST;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == kxd_pkg::REG_TABLE_SEED) begin
				table_seed_q <= cfg_data;
			end
			if (cfg_index == kxd_pkg::REG_START_KEY) begin
				start_key_q <= cfg_data;
			end
		end
	end

	// Table fill sequencer.
	kxd_fill #(
		.KEY_ENTRIES (KEY_ENTRIES)
	) u_fill (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cfg_we),
		.seed   (table_seed_q),
		.busy   (fill_busy),
		.addr   (fill_addr),
		.wr     (fill_wr)
	);

	// Input word fields and handshake.
	assign raw      = s_tdata[31:0];
	assign count    = s_tdata[34:32];
	assign is_full  = (count >= kxd_pkg::FULL_COUNT);
	assign s_tready = !fill_busy && (!m_tvalid_q || m_tready);
	assign s_acc    = s_tvalid && s_tready;

	// Table index: low chain bits reduced modulo the table depth by
	// restoring compare and subtract over the few quotient bits.
	always_comb begin
		rem = {1'b0, raw[kxd_pkg::IDX_W-1:0]};
		for (int b = QSTEPS - 1; b >= 0; b--) begin
			if (rem >= (kxd_pkg::IDX_W + 1)'(KEY_ENTRIES << b)) begin
				rem = rem - (kxd_pkg::IDX_W + 1)'(KEY_ENTRIES << b);
			end
		end
		rd_idx = rem[AW-1:0];
	end

	// Key table memory.
	kxd_ram #(
		.WIDTH (kxd_pkg::WORD_W),
		.DEPTH (KEY_ENTRIES)
	) u_key_ram (
		.clk   (clk),
		.we    (fill_wr.we),
		.waddr (fill_addr),
		.wdata (fill_wr.data),
		.re    (s_acc && is_full),
		.raddr (rd_idx),
		.rdata (rd_data)
	);

	// Key selection with the pending table read forwarded.
	always_comb begin
		if (s_tuser) begin
			key = start_key_q;
		end else if (pend_q) begin
			key = rd_data;
		end else begin
			key = chain_q;
		end
	end

	// Chain key: retire a pending read, or reload during a fill.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chain_q <= kxd_pkg::START_KEY_RST;
			pend_q  <= 1'b0;
		end else if (fill_busy) begin
			chain_q <= start_key_q;
			pend_q  <= 1'b0;
		end else begin
			if (pend_q) begin
				chain_q <= rd_data;
			end
			pend_q <= s_acc && is_full;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (s_acc) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_acc) begin
			m_tdata_q <= raw ^ (key & kxd_pkg::xor_mask(count));
			m_tlast_q <= !is_full;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;

	// Checks.
	`KXD_ASSERT_ALWAYS(a_no_word_in_fill, !(s_acc && fill_busy), "word accepted during table fill")
	`KXD_ASSERT_NEXT(a_word_to_output, s_acc, m_tvalid, "accepted word did not reach the output")
	`KXD_ASSERT_NEXT(a_full_reads_table, s_acc && is_full && !fill_busy, pend_q, "full word left no pending table read")
	`KXD_ASSERT_NEXT(a_fill_reload, fill_busy && !cfg_we, (chain_q == start_key_q) && !pend_q, "chain key not reloaded during fill")

endmodule

[verif/keychain_xor_packet_decryptor_tb.sv]
// ----------------------------------------------------------------------------
// keychain_xor_packet_decryptor_tb
// Streams encrypted packet words through the decryptor and compares every
// decrypted word with a local model of the key table and the key chain.
// Covers reset defaults, register writes with table refills, tails, odd byte
// counts, and random packets with idling on both stream sides.
// ----------------------------------------------------------------------------
module keychain_xor_packet_decryptor_tb;

	localparam int KEY_ENTRIES = kxd_pkg::DEF_KEY_ENTRIES;
	localparam int CYCLE_LIMIT = 1500000;
	localparam int RANDOM_PHASES = 3;
	localparam int WORDS_PER_PHASE = 620;

	// Register indexes that the block ignores.
	localparam logic [kxd_pkg::CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
	localparam logic [kxd_pkg::CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

	// Byte counts used by the stimulus.
	localparam logic [kxd_pkg::COUNT_W-1:0] CNT_NONE  = 3'd0;
	localparam logic [kxd_pkg::COUNT_W-1:0] CNT_ONE   = 3'd1;
	localparam logic [kxd_pkg::COUNT_W-1:0] CNT_TWO   = 3'd2;
	localparam logic [kxd_pkg::COUNT_W-1:0] CNT_THREE = 3'd3;
	localparam logic [kxd_pkg::COUNT_W-1:0] CNT_FIVE  = 3'd5;
	localparam logic [kxd_pkg::COUNT_W-1:0] CNT_SIX   = 3'd6;
	localparam logic [kxd_pkg::COUNT_W-1:0] CNT_SEVEN = 3'd7;

	typedef struct packed {
		logic [kxd_pkg::WORD_W-1:0] plain;
		logic                       tail;
	} plain_result_t;

	logic                          clk;
	logic                          arst_n;
	logic                          s_tvalid;
	logic                          s_tready;
	logic [39:0]                   s_tdata;  // raw_word, byte_count, zero pad
	logic                          s_tuser;  // packet_start
	logic                          m_tvalid;
	logic                          m_tready;
	logic [31:0]                   m_tdata;  // plain_word
	logic                          m_tlast;  // is_tail
	logic                          cfg_valid;
	logic                          cfg_ready;
	logic [kxd_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [kxd_pkg::WORD_W-1:0]    cfg_data;

	// Local copy of the decryptor state.
	logic [kxd_pkg::WORD_W-1:0] key_ram_copy [KEY_ENTRIES];
	logic [kxd_pkg::WORD_W-1:0] seed_reg;
	logic [kxd_pkg::WORD_W-1:0] first_key_reg;
	logic [kxd_pkg::WORD_W-1:0] running_key;

	plain_result_t pending_plain[$];
	plain_result_t oldest;

	int error_count;
	int cycle_count;
	int words_sent;
	int burst_left;

	// Receiver stall state.
	int                stall_left;
	int                stall_mode;
	int                stall_pos;
	logic [31:0]       stall_pattern;

	keychain_xor_packet_decryptor dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	// Clock with a period of 10.
	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Run limit in case the block hangs.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("keychain_xor_packet_decryptor_tb: done, errors");
			$finish;
		end
	end

	// Rebuild the key table from the seed, two generator outputs per entry.
	function void rebuild_key_table();
		logic [kxd_pkg::WORD_W-1:0] lcg;
		logic [kxd_pkg::WORD_W-1:0] scrambled;
		logic [kxd_pkg::HALF_W-1:0] lo_half;
		lcg = seed_reg;
		for (int i = 0; i < KEY_ENTRIES; i++) begin
			lcg = lcg * kxd_pkg::GEN_MUL + kxd_pkg::GEN_ADD;
			scrambled = (lcg >> 16) * kxd_pkg::OUT_MUL + kxd_pkg::OUT_ADD;
			lo_half = scrambled[31:16];
			lcg = lcg * kxd_pkg::GEN_MUL + kxd_pkg::GEN_ADD;
			scrambled = (lcg >> 16) * kxd_pkg::OUT_MUL + kxd_pkg::OUT_ADD;
			key_ram_copy[i] = {scrambled[31:16], lo_half};
		end
		running_key = first_key_reg;
	endfunction

	// Apply an accepted register write to the local state.
	function void apply_register(input logic [kxd_pkg::CFG_IDX_W-1:0] idx,
		input logic [kxd_pkg::WORD_W-1:0] value);
		case (idx)
			kxd_pkg::REG_TABLE_SEED: begin
				seed_reg = value;
				rebuild_key_table();
			end
			kxd_pkg::REG_START_KEY: begin
				first_key_reg = value;
				rebuild_key_table();
			end
			default: begin
			end
		endcase
	endfunction

	// Decrypt one accepted word and queue the expected output word.
	function void queue_plain_word(input logic [kxd_pkg::WORD_W-1:0] raw, input logic first,
		input logic [kxd_pkg::COUNT_W-1:0] count);
		logic [kxd_pkg::WORD_W-1:0] key;
		logic [kxd_pkg::WORD_W-1:0] mask;
		plain_result_t res;
		key = first ? first_key_reg : running_key;
		if (count >= kxd_pkg::FULL_COUNT) begin
			res.plain = raw ^ key;
			res.tail = 1'b0;
			running_key = key_ram_copy[raw[kxd_pkg::IDX_W-1:0] % KEY_ENTRIES];
		end else begin
			case (count)
				CNT_ONE:   mask = 32'h000000FF;
				CNT_TWO:   mask = 32'h0000FFFF;
				CNT_THREE: mask = 32'h00FFFFFF;
				default:   mask = 32'h00000000;
			endcase
			res.plain = raw ^ (key & mask);
			res.tail = 1'b1;
		end
		pending_plain.push_back(res);
	endfunction

	task automatic note_error(input string msg);
		error_count++;
		if (error_count <= 10)
			$display("mismatch: %s", msg);
	endtask

	// Compare every output word with the oldest expected word.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_plain.size() == 0) begin
				note_error($sformatf("unexpected word %h tail %b", m_tdata, m_tlast));
			end else begin
				oldest = pending_plain.pop_front();
				if (m_tdata !== oldest.plain)
					note_error($sformatf("plain word exp %h got %h", oldest.plain, m_tdata));
				if (m_tlast !== oldest.tail)
					note_error($sformatf("tail flag exp %b got %b", oldest.tail, m_tlast));
			end
		end
	end

	// Output side stalls: fully ready stretches, a rotating bit pattern, or
	// random stalls.
	always @(negedge clk) begin
		if (stall_left == 0) begin
			stall_mode = $urandom_range(0, 2);
			stall_left = $urandom_range(16, 96);
			stall_pattern = $urandom;
			stall_pos = 0;
		end
		stall_left--;
		case (stall_mode)
			0: m_tready = 1'b1;
			1: m_tready = stall_pattern[stall_pos % 32];
			default: m_tready = ($urandom_range(0, 3) != 0);
		endcase
		stall_pos++;
	end

	// Send one word; the sender idles between bursts of random length.
	task automatic send_word(input logic [kxd_pkg::WORD_W-1:0] raw, input logic first,
		input logic [kxd_pkg::COUNT_W-1:0] count);
		@(negedge clk);
		if (burst_left == 0) begin
			s_tvalid = 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
				: $urandom_range(1, 12);
		end
		burst_left--;
		s_tdata = {5'b0, count, raw};
		s_tuser = first;
		s_tvalid = 1'b1;
		do @(posedge clk); while (!s_tready);
		queue_plain_word(raw, first, count);
		words_sent++;
	endtask

	// Stop sending and wait until every expected word has come out.
	task automatic drain_results();
		@(negedge clk);
		s_tvalid = 1'b0;
		while (pending_plain.size() != 0) @(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	// Write one register while the stream is idle.
	task automatic write_register(input logic [kxd_pkg::CFG_IDX_W-1:0] idx,
		input logic [kxd_pkg::WORD_W-1:0] value);
		drain_results();
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = value;
		do @(posedge clk); while (!cfg_ready);
		apply_register(idx, value);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// After reset the chain starts from the start key even without a start flag.
	task automatic test_reset_chain();
		send_word(32'h00000000, 1'b0, kxd_pkg::FULL_COUNT);
		send_word(32'hFFFFFFFF, 1'b0, kxd_pkg::FULL_COUNT);
		send_word(32'h12345678, 1'b0, CNT_THREE);
		send_word(32'hA5A5A5A5, 1'b0, kxd_pkg::FULL_COUNT);
	endtask

	// Field extremes, tails of every size, empty tail and oversized counts.
	task automatic test_byte_counts();
		send_word(32'hFFFFFFFF, 1'b1, kxd_pkg::FULL_COUNT);
		send_word(32'h00003FFF, 1'b0, kxd_pkg::FULL_COUNT);
		send_word(32'hFFFFFFFF, 1'b0, CNT_ONE);
		send_word(32'hFFFFFFFF, 1'b0, CNT_TWO);
		send_word(32'h00000000, 1'b1, CNT_THREE);
		send_word(32'hFFFFFFFF, 1'b0, CNT_NONE);
		send_word(32'h80000000, 1'b1, CNT_NONE);
		send_word(32'h7FFFFFFF, 1'b0, CNT_FIVE);
		send_word(32'h00000000, 1'b0, CNT_SIX);
		send_word(32'hFFFFC000, 1'b1, CNT_SEVEN);
		send_word(32'h0F0F0F0F, 1'b0, kxd_pkg::FULL_COUNT);
		send_word(32'hF0F0F0F0, 1'b0, CNT_ONE);
		send_word(32'h00000000, 1'b0, kxd_pkg::FULL_COUNT);
	endtask

	// Register extremes; each write reloads the chain key.
	task automatic test_register_writes();
		write_register(kxd_pkg::REG_TABLE_SEED, 32'h00000000);
		send_word(32'h00001234, 1'b0, kxd_pkg::FULL_COUNT);
		send_word(32'hCAFE0001, 1'b0, kxd_pkg::FULL_COUNT);
		write_register(kxd_pkg::REG_START_KEY, 32'h00000000);
		send_word(32'hDEADBEEF, 1'b0, kxd_pkg::FULL_COUNT);
		send_word(32'h13572468, 1'b1, CNT_TWO);
		write_register(kxd_pkg::REG_TABLE_SEED, 32'hFFFFFFFF);
		send_word(32'hFFFFFFFF, 1'b1, kxd_pkg::FULL_COUNT);
		send_word(32'h00000001, 1'b0, kxd_pkg::FULL_COUNT);
		write_register(kxd_pkg::REG_START_KEY, 32'hFFFFFFFF);
		send_word(32'h00000000, 1'b0, kxd_pkg::FULL_COUNT);
		send_word(32'h55AA55AA, 1'b1, CNT_ONE);
	endtask

	// Writes to unused indexes change nothing, so the chain carries on.
	task automatic test_spare_indexes();
		send_word($urandom, 1'b0, kxd_pkg::FULL_COUNT);
		write_register(REG_SPARE_2, $urandom);
		write_register(REG_SPARE_3, $urandom);
		send_word($urandom, 1'b0, kxd_pkg::FULL_COUNT);
	endtask

	// One packet: mostly well formed with random contents, some noise.
	task automatic send_random_packet();
		int n;
		if ($urandom_range(0, 9) < 8) begin
			n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 8);
			send_word($urandom, 1'b1, kxd_pkg::FULL_COUNT);
			repeat (n) send_word($urandom, 1'b0, kxd_pkg::FULL_COUNT);
			if ($urandom_range(0, 1))
				send_word($urandom, 1'b0, kxd_pkg::COUNT_W'($urandom_range(1, 3)));
		end else begin
			n = $urandom_range(1, 4);
			repeat (n) send_word($urandom, 1'($urandom_range(0, 1)),
				kxd_pkg::COUNT_W'($urandom_range(0, 7)));
		end
	endtask

	// Random traffic in phases, each under a new register setting, with one
	// full pause partway through.
	task automatic test_random_packets();
		int phase_goal;
		logic paused;
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			write_register($urandom_range(0, 1) ? kxd_pkg::REG_START_KEY
				: kxd_pkg::REG_TABLE_SEED, $urandom);
			phase_goal = words_sent + WORDS_PER_PHASE;
			paused = 1'b0;
			while (words_sent < phase_goal) begin
				send_random_packet();
				if (!paused && words_sent > phase_goal - WORDS_PER_PHASE / 2) begin
					drain_results();
					paused = 1'b1;
				end
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = 1'b0;
		m_tready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = kxd_pkg::REG_TABLE_SEED;
		cfg_data = '0;
		error_count = 0;
		cycle_count = 0;
		words_sent = 0;
		burst_left = 0;
		stall_left = 0;
		stall_mode = 0;
		stall_pos = 0;
		stall_pattern = '0;
		seed_reg = kxd_pkg::TABLE_SEED_RST;
		first_key_reg = kxd_pkg::START_KEY_RST;
		rebuild_key_table();
		repeat (9) @(negedge clk);
		arst_n = 1'b1;

		test_reset_chain();
		test_byte_counts();
		test_register_writes();
		test_spare_indexes();
		test_random_packets();

		drain_results();
		repeat (4) @(posedge clk);
		if (error_count == 0)
			$display("keychain_xor_packet_decryptor_tb: done, clean");
		else
			$display("keychain_xor_packet_decryptor_tb: done, errors");
		$finish;
	end

endmodule
